// File: sv/priority_register_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the register allocator
// Clocked, reset-qualified wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_REGISTER_ALLOCATOR_MACROS_SVH
`define PRIORITY_REGISTER_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define PRA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/pra_pkg.sv
// ----------------------------------------------------------------------------
// pra_pkg
// Types and constants shared by the register allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pra_pkg;

  localparam int unsigned NUM_VARS        = 256;
  localparam int unsigned VAR_W           = 8;
  localparam int unsigned NUM_INT_SLOTS   = 24;
  localparam int unsigned NUM_FLOAT_SLOTS = 25;
  localparam int unsigned NUM_SLOTS       = NUM_INT_SLOTS + NUM_FLOAT_SLOTS;
  localparam int unsigned SLOT_W          = 6;
  localparam int unsigned TYPE_W          = 3;

  localparam logic [NUM_SLOTS-1:0] INT_MASK = NUM_SLOTS'((64'd1 << NUM_INT_SLOTS) - 64'd1);
  localparam logic [NUM_SLOTS-1:0] FLT_MASK = ~INT_MASK;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ALLOC_INT = 3'd0,
    REQ_ALLOC_FLT = 3'd1,
    REQ_REL_VAR   = 3'd2,
    REQ_REL_REG   = 3'd3,
    REQ_CLAIM     = 3'd4,
    REQ_QUERY     = 3'd5
  } req_e;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [VAR_W-1:0]  var_id;
    logic [SLOT_W-1:0] reg_slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]    reg_out;
    logic                 reg_valid;
    logic                 spill;
    logic [NUM_SLOTS-1:0] used_now_map;
    logic [NUM_SLOTS-1:0] ever_used_map;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch request, launch binding reads
    logic exec;     // apply request, load result register
  } cmd_t;

endpackage

// File: sv/pra_chan_if.sv
// ----------------------------------------------------------------------------
// pra_chan_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pra_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/priority_register_allocator.sv
// ----------------------------------------------------------------------------
// priority_register_allocator
// Two-pool register allocator with variable/register bindings.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                       handshake
//  -------  ---  --------------------------------------------  -----------
//  req_i    in   req_type, var_id, reg_slot                    valid/ready
//  rsp_o    out  reg_out, reg_valid, spill, used/ever maps     valid/ready
//
//  The binding RAMs have a registered read port, so the capture step reads
//  them and the exec step applies the update and loads the result.
//  Reset is immediate: binding valid bits live in flops, no clearing pass.
//  One request in flight; the next one is taken while a result waits.
//  A stalled result holds the apply step until the output register drains.
//
`timescale 1ns / 1ps

module priority_register_allocator (
  input  logic             clk_i,
  input  logic             rst_ni,
  pra_chan_if.sink         req_i,
  pra_chan_if.source       rsp_o
);

  pra_pkg::cmd_t cmd;
  pra_pkg::rsp_t rsp;

  // Sequencer: issues capture on acceptance, exec once the result slot frees
  pra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // Maps, bindings and the result register
  pra_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i.data),
    .rsp_o  (rsp)
  );

  assign rsp_o.data = rsp;

endmodule

// File: sv/pra_ram.sv
// ----------------------------------------------------------------------------
// pra_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/pra_ctrl.sv
// ----------------------------------------------------------------------------
// pra_ctrl
// Request sequencer: read binding memories, then apply and post the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pra_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output pra_pkg::cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;

  always_comb begin
    req_ready_o   = (state_q == ST_IDLE);
    cmd_o.capture = req_valid_i && req_ready_o;
    // result register must be empty or emptying this cycle
    cmd_o.exec    = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready_i);

    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd_o.exec) state_d = ST_IDLE;
      end
    endcase

    rsp_valid_d = rsp_valid_q;
    if (cmd_o.exec) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

// File: sv/pra_dp.sv
// ----------------------------------------------------------------------------
// pra_dp
// Allocator datapath: slot maps, binding memories with valid bits, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pra_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pra_pkg::cmd_t cmd_i,
  input  pra_pkg::req_t req_i,
  output pra_pkg::rsp_t rsp_o
);

  localparam int unsigned NS = pra_pkg::NUM_SLOTS;
  localparam int unsigned SW = pra_pkg::SLOT_W;
  localparam int unsigned VW = pra_pkg::VAR_W;
  localparam int unsigned NV = pra_pkg::NUM_VARS;

  // lowest set bit, priority to slot 0
  function automatic logic [SW-1:0] lowest_slot(input logic [NS-1:0] m);
    logic [SW-1:0] idx;
    idx = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (m[i]) idx = SW'(i);
    end
    return idx;
  endfunction

  // latched request
  logic [pra_pkg::TYPE_W-1:0] type_q;
  logic [VW-1:0]              var_q;
  logic [SW-1:0]              slot_q;

  // state; free map is the complement of in_use
  logic [NS-1:0] in_use_q, in_use_d;
  logic [NS-1:0] touched_q, touched_d;
  logic [NV-1:0] var_vld_q, var_vld_d;
  logic [NS-1:0] reg_vld_q, reg_vld_d;

  // memory ports
  logic          var_we, reg_we;
  logic [VW-1:0] var_waddr;
  logic [SW-1:0] var_wdata, var_rdata;
  logic [SW-1:0] reg_waddr, reg_raddr;
  logic [VW-1:0] reg_wdata, reg_rdata;

  logic          var_hit, slot_ok, slot_flt, cls_free, found;
  logic [NS-1:0] free_map, cand;
  logic [SW-1:0] cand_slot;
  pra_pkg::rsp_t rsp_d, rsp_q;

  assign reg_raddr = (req_i.reg_slot < SW'(NS)) ? req_i.reg_slot : '0;

  pra_ram #(.WIDTH(SW), .DEPTH(NV)) u_var_ram (
    .clk_i   (clk_i),
    .we_i    (var_we),
    .waddr_i (var_waddr),
    .wdata_i (var_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (req_i.var_id),
    .rdata_o (var_rdata)
  );

  pra_ram #(.WIDTH(VW), .DEPTH(NS)) u_reg_ram (
    .clk_i   (clk_i),
    .we_i    (reg_we),
    .waddr_i (reg_waddr),
    .wdata_i (reg_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (reg_raddr),
    .rdata_o (reg_rdata)
  );

  always_comb begin
    free_map  = ~in_use_q;
    var_hit   = var_vld_q[var_q];
    slot_ok   = slot_q < SW'(NS);
    slot_flt  = slot_q >= SW'(pra_pkg::NUM_INT_SLOTS);
    cls_free  = |(free_map & (slot_flt ? pra_pkg::FLT_MASK : pra_pkg::INT_MASK));
    cand      = free_map & ((pra_pkg::req_e'(type_q) == pra_pkg::REQ_ALLOC_FLT)
                            ? pra_pkg::FLT_MASK : pra_pkg::INT_MASK);
    found     = |cand;
    cand_slot = lowest_slot(cand);

    in_use_d  = in_use_q;
    touched_d = touched_q;
    var_vld_d = var_vld_q;
    reg_vld_d = reg_vld_q;
    var_we    = 1'b0;
    var_waddr = var_q;
    var_wdata = cand_slot;
    reg_we    = 1'b0;
    reg_waddr = cand_slot;
    reg_wdata = var_q;
    rsp_d     = '0;

    if (cmd_i.exec) begin
      unique case (pra_pkg::req_e'(type_q))
        pra_pkg::REQ_ALLOC_INT, pra_pkg::REQ_ALLOC_FLT: begin
          if (var_hit) begin
            rsp_d.reg_out   = var_rdata;
            rsp_d.reg_valid = 1'b1;
          end else if (found) begin
            in_use_d[cand_slot]  = 1'b1;
            touched_d[cand_slot] = 1'b1;
            reg_vld_d[cand_slot] = 1'b1;
            var_vld_d[var_q]     = 1'b1;
            var_we               = 1'b1;
            reg_we               = 1'b1;
            rsp_d.reg_out        = cand_slot;
            rsp_d.reg_valid      = 1'b1;
          end else begin
            rsp_d.spill = 1'b1;
          end
        end
        pra_pkg::REQ_REL_VAR: begin
          // bindings are kept pairwise, so both sides clear together
          if (var_hit) begin
            in_use_d[var_rdata]  = 1'b0;
            reg_vld_d[var_rdata] = 1'b0;
            var_vld_d[var_q]     = 1'b0;
            rsp_d.reg_out        = var_rdata;
            rsp_d.reg_valid      = 1'b1;
          end
        end
        pra_pkg::REQ_REL_REG: begin
          if (slot_ok) begin
            in_use_d[slot_q] = 1'b0;
            if (reg_vld_q[slot_q]) begin
              reg_vld_d[slot_q]    = 1'b0;
              var_vld_d[reg_rdata] = 1'b0;
            end
            rsp_d.reg_out   = slot_q;
            rsp_d.reg_valid = 1'b1;
          end
        end
        pra_pkg::REQ_CLAIM: begin
          if (slot_ok) begin
            if (!cls_free) begin
              rsp_d.spill = 1'b1;
            end else begin
              in_use_d[slot_q]  = 1'b1;
              touched_d[slot_q] = 1'b1;
              rsp_d.reg_out     = slot_q;
              rsp_d.reg_valid   = 1'b1;
            end
          end
        end
        pra_pkg::REQ_QUERY: begin
          if (var_hit) begin
            rsp_d.reg_out   = var_rdata;
            rsp_d.reg_valid = 1'b1;
          end
        end
        default: ;
      endcase
    end

    rsp_d.used_now_map  = in_use_d;
    rsp_d.ever_used_map = touched_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q  <= '0;
      touched_q <= '0;
      var_vld_q <= '0;
      reg_vld_q <= '0;
    end else begin
      in_use_q  <= in_use_d;
      touched_q <= touched_d;
      var_vld_q <= var_vld_d;
      reg_vld_q <= reg_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      type_q <= req_i.req_type;
      var_q  <= req_i.var_id;
      slot_q <= req_i.reg_slot;
    end
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// File: sv/pra_checker.sv
// ----------------------------------------------------------------------------
// pra_checker
// Port-level checks on the allocator, bound into the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "priority_register_allocator_macros.svh"

module pra_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_i,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input pra_pkg::rsp_t rsp_data_i
);

  `PRA_ASSERT_NOW(a_spill_excl, clk_i, rst_ni, rsp_valid_i, !(rsp_data_i.reg_valid && rsp_data_i.spill), "spill with valid register")
  `PRA_ASSERT_NOW(a_slot_form, clk_i, rst_ni, rsp_valid_i, (rsp_data_i.reg_valid && (rsp_data_i.reg_out < pra_pkg::NUM_SLOTS)) || (!rsp_data_i.reg_valid && (rsp_data_i.reg_out == '0)), "bad reg_out")
  `PRA_ASSERT_NOW(a_ever_covers, clk_i, rst_ni, rsp_valid_i, (rsp_data_i.used_now_map & ~rsp_data_i.ever_used_map) == '0, "used slot never marked")
  `PRA_ASSERT_NEXT(a_one_inflight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "second request taken early")
  `PRA_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_data_i), "stalled result changed")

endmodule

bind priority_register_allocator pra_checker u_pra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench - priority_register_allocator
// Self-checking bench for the two-pool register allocator. A shadow copy of
// the free, in-use and ever-used maps and of both binding tables predicts
// every reply. Each reply is checked field by field against the oldest
// prediction. Directed corner requests come first. Pool exhaustion with
// spills follows, then long random request mixes under varying back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pra_pkg::*;

  // Request codes 6 and 7 are undefined; the block must answer with a null reply.
  localparam logic [TYPE_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [TYPE_W-1:0] REQ_SPARE_7 = 3'd7;

  // Way above the slowest legal run (about 700 requests).
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PRINT_CAP   = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  pra_chan_if #(.T(req_t)) req_if ();
  pra_chan_if #(.T(rsp_t)) rsp_if ();

  priority_register_allocator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // --------------------------------------------------------------------------
  // Shadow allocator state
  // --------------------------------------------------------------------------
  logic [NUM_SLOTS-1:0] shadow_free;
  logic [NUM_SLOTS-1:0] shadow_in_use;
  logic [NUM_SLOTS-1:0] shadow_touched;
  logic                 var_live [NUM_VARS];
  logic [SLOT_W-1:0]    var_slot [NUM_VARS];
  logic                 reg_live [NUM_SLOTS];
  logic [VAR_W-1:0]     reg_var  [NUM_SLOTS];

  rsp_t        grant_fifo[$];   // predicted replies, oldest first
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned replies_checked;
  int unsigned spills_seen;
  int unsigned kind_count [8];
  int unsigned cycle_count;

  // Slots of one class: integer pool low, float pool above it.
  function automatic logic [NUM_SLOTS-1:0] class_bits(input bit is_float);
    logic [NUM_SLOTS-1:0] m;
    m = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      m[i] = is_float ? (i >= NUM_INT_SLOTS) : (i < NUM_INT_SLOTS);
    end
    return m;
  endfunction

  // Free a slot and drop its binding; the variable side goes only if it still points here.
  function automatic void free_shadow_slot(input int unsigned s);
    shadow_in_use[s] = 1'b0;
    shadow_free[s]   = 1'b1;
    if (reg_live[s]) begin
      if (var_live[reg_var[s]] && var_slot[reg_var[s]] == s) var_live[reg_var[s]] = 1'b0;
      reg_live[s] = 1'b0;
    end
  endfunction

  // Apply one request to the shadow and return the reply it must produce.
  function automatic rsp_t apply_to_shadow(input req_t r);
    rsp_t                 g;
    logic [NUM_SLOTS-1:0] avail;
    logic [VAR_W-1:0]     v;
    int                   pick;
    g    = '0;
    v    = r.var_id;
    pick = -1;
    case (r.req_type)
      REQ_ALLOC_INT, REQ_ALLOC_FLT: begin
        if (var_live[v]) begin
          g.reg_out   = var_slot[v];
          g.reg_valid = 1'b1;
        end else begin
          avail = shadow_free & class_bits(r.req_type == REQ_ALLOC_FLT);
          for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (avail[i]) pick = i;
          end
          if (pick < 0) begin
            g.spill = 1'b1;
          end else begin
            shadow_free[pick]    = 1'b0;
            shadow_in_use[pick]  = 1'b1;
            shadow_touched[pick] = 1'b1;
            reg_live[pick]       = 1'b1;
            reg_var[pick]        = v;
            var_live[v]          = 1'b1;
            var_slot[v]          = SLOT_W'(pick);
            g.reg_out            = SLOT_W'(pick);
            g.reg_valid          = 1'b1;
          end
        end
      end
      REQ_REL_VAR: begin
        if (var_live[v] && var_slot[v] < NUM_SLOTS) begin
          g.reg_out   = var_slot[v];
          g.reg_valid = 1'b1;
          free_shadow_slot(var_slot[v]);
          var_live[v] = 1'b0;
        end
      end
      REQ_REL_REG: begin
        if (r.reg_slot < NUM_SLOTS) begin
          free_shadow_slot(r.reg_slot);
          g.reg_out   = r.reg_slot;
          g.reg_valid = 1'b1;
        end
      end
      REQ_CLAIM: begin
        // Fails only when the whole class is exhausted, even if the slot is busy.
        if (r.reg_slot < NUM_SLOTS) begin
          if ((shadow_free & class_bits(r.reg_slot >= NUM_INT_SLOTS)) == '0) begin
            g.spill = 1'b1;
          end else begin
            shadow_free[r.reg_slot]    = 1'b0;
            shadow_in_use[r.reg_slot]  = 1'b1;
            shadow_touched[r.reg_slot] = 1'b1;
            g.reg_out                  = r.reg_slot;
            g.reg_valid                = 1'b1;
          end
        end
      end
      REQ_QUERY: begin
        if (var_live[v]) begin
          g.reg_out   = var_slot[v];
          g.reg_valid = 1'b1;
        end
      end
      default: ;  // spare codes: null reply, no state change
    endcase
    g.used_now_map  = shadow_in_use;
    g.ever_used_map = shadow_touched;
    return g;
  endfunction

  // A variable that currently holds a register, or any variable if the pick misses.
  function automatic logic [VAR_W-1:0] bound_var_or_any();
    int unsigned s;
    s = $urandom_range(NUM_SLOTS - 1);
    return reg_live[s] ? reg_var[s] : VAR_W'($urandom_range(255));
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: optional idle gap, then hold valid until accepted.
  // Valid is left high after acceptance; the next call (or the end of the run)
  // decides within the same step whether it drops or carries a new request.
  // --------------------------------------------------------------------------
  task automatic send_req(input logic [TYPE_W-1:0] kind, input logic [VAR_W-1:0] var_no,
                          input logic [SLOT_W-1:0] slot);
    req_t r;
    r.req_type = kind;
    r.var_id   = var_no;
    r.reg_slot = slot;
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    grant_fifo.push_back(apply_to_shadow(r));
    requests_sent++;
    kind_count[kind]++;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
  endtask

  // --------------------------------------------------------------------------
  // Reply checker and receiver back-pressure
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (grant_fifo.size() == 0) begin
        report_mismatch("reply with no request outstanding", got.reg_out, 0);
      end else begin
        want = grant_fifo.pop_front();
        if (got.reg_out !== want.reg_out) report_mismatch("reg_out", got.reg_out, want.reg_out);
        if (got.reg_valid !== want.reg_valid)
          report_mismatch("reg_valid", got.reg_valid, want.reg_valid);
        if (got.spill !== want.spill) report_mismatch("spill", got.spill, want.spill);
        if (got.used_now_map !== want.used_now_map)
          report_mismatch("used_now_map", got.used_now_map, want.used_now_map);
        if (got.ever_used_map !== want.ever_used_map)
          report_mismatch("ever_used_map", got.ever_used_map, want.ever_used_map);
        if (want.spill) spills_seen++;
        replies_checked++;
      end
    end
  end

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner requests from a fresh reset: rebinding, cross-class rebinding,
  // unbound queries and releases, claims of busy slots, out-of-range slots,
  // spare codes, and field extremes.
  task automatic test_corner_requests();
    send_req(REQ_ALLOC_INT, 8'd0,   6'd0);
    send_req(REQ_ALLOC_INT, 8'd255, 6'd63);
    send_req(REQ_ALLOC_INT, 8'd0,   6'd0);   // existing binding returned
    send_req(REQ_ALLOC_FLT, 8'd128, 6'd0);
    send_req(REQ_ALLOC_FLT, 8'd0,   6'd0);   // bound int register wins over class
    send_req(REQ_QUERY,     8'd255, 6'd0);
    send_req(REQ_QUERY,     8'd77,  6'd0);   // never bound
    send_req(REQ_REL_VAR,   8'd0,   6'd0);
    send_req(REQ_REL_VAR,   8'd0,   6'd0);   // already released
    send_req(REQ_CLAIM,     8'd0,   6'd48);  // top float slot
    send_req(REQ_CLAIM,     8'd0,   6'd0);
    send_req(REQ_CLAIM,     8'd0,   6'd0);   // busy slot claimed again
    send_req(REQ_REL_REG,   8'd0,   6'd1);   // clears binding of var 255
    send_req(REQ_QUERY,     8'd255, 6'd0);
    send_req(REQ_REL_REG,   8'd0,   6'd23);  // never used
    send_req(REQ_CLAIM,     8'd0,   6'd49);  // first slot out of range
    send_req(REQ_CLAIM,     8'd255, 6'd63);
    send_req(REQ_REL_REG,   8'd255, 6'd63);
    send_req(REQ_SPARE_6,   8'd255, 6'd63);
    send_req(REQ_SPARE_7,   8'd0,   6'd0);
    send_req(REQ_ALLOC_INT, 8'd200, 6'd24);  // lowest free int slot is 1 again
    send_req(REQ_REL_REG,   8'd0,   6'd48);  // claimed slot without binding
    send_req(REQ_REL_REG,   8'd0,   6'd0);   // claimed over a dead binding
    send_req(REQ_ALLOC_FLT, 8'd42,  6'd24);
  endtask

  // Fill both pools, check spills on allocate and claim, then empty everything.
  task automatic test_pool_exhaustion();
    int unsigned      guard;
    int unsigned      start;
    int unsigned      s;
    logic [VAR_W-1:0] v;
    guard = 0;
    while (((shadow_free & class_bits(1'b0)) != '0 || (shadow_free & class_bits(1'b1)) != '0)
           && guard < 300) begin
      if ($urandom_range(9) == 0) begin
        send_req(REQ_QUERY, VAR_W'($urandom_range(255)), SLOT_W'($urandom_range(63)));
      end else begin
        send_req($urandom_range(1) ? REQ_ALLOC_FLT : REQ_ALLOC_INT,
                 VAR_W'($urandom_range(255)), SLOT_W'($urandom_range(63)));
      end
      guard++;
    end
    // Both pools dry: fresh variables must spill, and so must any claim.
    for (int k = 0; k < 4; k++) begin
      v = VAR_W'($urandom_range(255));
      while (var_live[v]) v = VAR_W'($urandom_range(255));
      send_req(k[0] ? REQ_ALLOC_FLT : REQ_ALLOC_INT, v, SLOT_W'($urandom_range(63)));
      send_req(REQ_CLAIM, VAR_W'($urandom_range(255)),
               k[0] ? SLOT_W'($urandom_range(NUM_SLOTS - 1, NUM_INT_SLOTS))
                    : SLOT_W'($urandom_range(NUM_INT_SLOTS - 1)));
    end
    // Drain: sweep every slot from a random start, by variable where bound.
    start = $urandom_range(NUM_SLOTS - 1);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      s = (start + i) % NUM_SLOTS;
      if (reg_live[s] && $urandom_range(1)) begin
        send_req(REQ_REL_VAR, reg_var[s], SLOT_W'($urandom_range(63)));
      end else begin
        send_req(REQ_REL_REG, VAR_W'($urandom_range(255)), SLOT_W'(s));
      end
    end
  endtask

  // Random request mix in bursts that lean towards filling, draining or neither.
  task automatic test_random_mix(input int unsigned count);
    int unsigned       roll;
    int unsigned       t_alloc, t_relv, t_relr, t_claim, t_query;
    logic [VAR_W-1:0]  v;
    logic [SLOT_W-1:0] s;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       begin t_alloc = 60; t_relv = 68; t_relr = 74; t_claim = 84; t_query = 97; end
          1:       begin t_alloc = 18; t_relv = 48; t_relr = 70; t_claim = 76; t_query = 97; end
          default: begin t_alloc = 38; t_relv = 56; t_relr = 68; t_claim = 80; t_query = 97; end
        endcase
      end
      roll = $urandom_range(99);
      v    = VAR_W'($urandom_range(255));
      s    = ($urandom_range(9) == 0) ? SLOT_W'($urandom_range(63))
                                      : SLOT_W'($urandom_range(NUM_SLOTS - 1));
      if (roll < t_alloc) begin
        if ($urandom_range(3) == 0) v = bound_var_or_any();
        send_req($urandom_range(1) ? REQ_ALLOC_FLT : REQ_ALLOC_INT, v, s);
      end else if (roll < t_relv) begin
        send_req(REQ_REL_VAR, ($urandom_range(4) == 0) ? v : bound_var_or_any(), s);
      end else if (roll < t_relr) begin
        send_req(REQ_REL_REG, v, s);
      end else if (roll < t_claim) begin
        send_req(REQ_CLAIM, v, s);
      end else if (roll < t_query) begin
        send_req(REQ_QUERY, $urandom_range(1) ? v : bound_var_or_any(), s);
      end else begin
        send_req($urandom_range(1) ? REQ_SPARE_6 : REQ_SPARE_7, v, s);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    req_if.valid    <= 1'b0;
    req_if.data     <= '0;
    shadow_free     = '1;
    shadow_in_use   = '0;
    shadow_touched  = '0;
    for (int i = 0; i < NUM_VARS; i++) begin
      var_live[i] = 1'b0;
      var_slot[i] = '0;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      reg_live[i] = 1'b0;
      reg_var[i]  = '0;
    end
    mismatches      = 0;
    requests_sent   = 0;
    replies_checked = 0;
    spills_seen     = 0;
    cycle_count     = 0;
    for (int i = 0; i < 8; i++) kind_count[i] = 0;

    // Sender lazy, receiver stalling hard
    tx_idle_pct = 18;
    rx_idle_pct = 49;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_corner_requests();
    test_pool_exhaustion();
    test_random_mix(150);

    // Roles swapped
    tx_idle_pct = 49;
    rx_idle_pct = 18;
    test_random_mix(150);

    // Full throughput
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_pool_exhaustion();
    test_random_mix(120);

    req_if.valid <= 1'b0;
    while (grant_fifo.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Requests: %0d (alloc %0d/%0d, release %0d/%0d, claim %0d, query %0d, spare %0d)",
             requests_sent, kind_count[REQ_ALLOC_INT], kind_count[REQ_ALLOC_FLT],
             kind_count[REQ_REL_VAR], kind_count[REQ_REL_REG], kind_count[REQ_CLAIM],
             kind_count[REQ_QUERY], kind_count[REQ_SPARE_6] + kind_count[REQ_SPARE_7]);
    $display("Replies checked: %0d, spills among them: %0d, mismatches: %0d",
             replies_checked, spills_seen, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
